FILE: rtl/psched_pkg.sv
// Package with the shared types, codes and defaults of the priority scheduler.
`timescale 1ns / 1ps

package psched_pkg;

  localparam int SlotsDefault = 16;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  priority_req;
  } in_t;

  typedef struct packed {
    logic        busy_res;
    logic [3:0]  run_slot;
    logic [31:0] tick_time;
    logic        finished;
    logic [31:0] start_time;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        all_done;
  } out_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic [31:0] start;
  } entry_t;

  typedef struct packed {
    logic start;
    logic vld;
  } sel_ctrl_t;

endpackage

FILE: rtl/psched_mem.sv
// Task table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module psched_mem #(
  parameter int Slots = psched_pkg::SlotsDefault,
  parameter int IdxW  = $clog2(Slots)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  psched_pkg::entry_t  wdata_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  output psched_pkg::entry_t  rdata_o
);

  psched_pkg::entry_t mem_q [Slots];
  psched_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/psched_sel.sv
// Selection stage that compares one table entry per cycle against the best candidate.
`timescale 1ns / 1ps

module psched_sel #(
  parameter int Slots = psched_pkg::SlotsDefault,
  parameter int IdxW  = $clog2(Slots),
  parameter int CntW  = $clog2(Slots + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psched_pkg::sel_ctrl_t ctrl_i,
  input  logic [IdxW-1:0]       idx_i,
  input  psched_pkg::entry_t    rdata_i,
  input  logic                  used_i,
  input  logic [31:0]           time_i,
  output logic                  found_o,
  output logic [IdxW-1:0]       best_idx_o,
  output psched_pkg::entry_t    best_o,
  output logic [CntW-1:0]       active_o
);

  logic               found_q, found_d;
  logic [CntW-1:0]    active_q, active_d;
  logic [IdxW-1:0]    best_idx_q;
  psched_pkg::entry_t best_q;
  logic               pend, elig, better, take;

  always_comb begin
    pend   = used_i && (rdata_i.remaining != 16'd0);
    elig   = pend && ({16'd0, rdata_i.arrival} <= time_i);
    better = !found_q || (rdata_i.prio < best_q.prio) ||
             ((rdata_i.prio == best_q.prio) && (rdata_i.arrival < best_q.arrival));
    take   = ctrl_i.vld && elig && better;
    found_d  = found_q;
    active_d = active_q;
    if (ctrl_i.start) begin
      found_d  = 1'b0;
      active_d = '0;
    end else if (ctrl_i.vld) begin
      if (take) begin
        found_d = 1'b1;
      end
      if (pend) begin
        active_d = active_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      active_q <= '0;
    end else begin
      found_q  <= found_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q     <= rdata_i;
      best_idx_q <= idx_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_o     = best_q;
  assign active_o   = active_q;

endmodule

FILE: rtl/preemptive_priority_scheduler_top.sv
// Top level of the preemptive priority scheduler with the tick sequencer.
`timescale 1ns / 1ps

// A load, a clear or an unknown action is done in the idle state and gives no result. A tick
// stalls the input from its transfer until its write-back: the task table sits in one
// memory with a single read port, so the tick scans it one entry per cycle, then does the
// last compare, the turnaround sum and the write-back that updates the chosen entry and
// loads the result register. The result register lets the next input transfer proceed while
// a result still waits; a tick only holds in its write-back state when the previous result
// has not yet been taken.
module preemptive_priority_scheduler_top #(
  parameter int SLOTS = psched_pkg::SlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psched_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psched_pkg::out_t  out_data_o
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StLast  = 3'd2;
  localparam logic [2:0] StCalc  = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [31:0]           time_q, time_d;
  logic [SLOTS-1:0]      used_q, used_d;
  logic [IdxW-1:0]       addr_q, addr_d;
  logic                  rd_vld_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [31:0]           tat_q;
  logic                  out_valid_q, out_valid_d;
  psched_pkg::out_t      out_q, out_d;

  psched_pkg::sel_ctrl_t sel_ctrl;
  logic                  found;
  logic [IdxW-1:0]       best_idx;
  psched_pkg::entry_t    best;
  logic [CntW-1:0]       active;
  psched_pkg::entry_t    rdata;

  logic                  in_xfer, load_ok, out_free, wb_go, finished;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  psched_pkg::entry_t    mem_wdata, upd;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load_ok    = in_xfer && (in_data_i.action == psched_pkg::ACT_LOAD) &&
                      (32'(in_data_i.slot) < SLOTS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign wb_go      = (state_q == StWrite) && out_free;
  assign finished   = found && (best.remaining == 16'd1);

  always_comb begin
    upd           = best;
    upd.remaining = best.remaining - 16'd1;
    if (best.remaining == best.burst) begin
      upd.start = time_q;
    end
  end

  always_comb begin
    mem_we    = load_ok || (wb_go && found);
    mem_waddr = best_idx;
    mem_wdata = upd;
    if (state_q == StIdle) begin
      mem_waddr           = IdxW'(in_data_i.slot);
      mem_wdata.arrival   = in_data_i.arrival;
      mem_wdata.burst     = in_data_i.burst;
      mem_wdata.remaining = in_data_i.burst;
      mem_wdata.prio      = in_data_i.priority_req;
      mem_wdata.start     = 32'd0;
    end
  end

  always_comb begin
    out_d             = '0;
    out_d.busy_res    = found;
    out_d.tick_time   = time_q;
    out_d.all_done    = (active == CntW'(finished));
    if (found) begin
      out_d.run_slot = 4'(best_idx);
    end
    if (finished) begin
      out_d.finished    = 1'b1;
      out_d.start_time  = upd.start;
      out_d.finish_time = time_q + 32'd1;
      out_d.turnaround  = tat_q;
      out_d.waiting     = tat_q - {16'd0, best.burst};
    end
  end

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    used_d      = used_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    sel_ctrl    = '0;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          unique case (in_data_i.action)
            psched_pkg::ACT_LOAD: begin
              if (load_ok) begin
                used_d[IdxW'(in_data_i.slot)] = 1'b1;
              end
            end
            psched_pkg::ACT_TICK: begin
              state_d        = StScan;
              addr_d         = '0;
              sel_ctrl.start = 1'b1;
            end
            psched_pkg::ACT_CLEAR: begin
              time_d = '0;
              used_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      StScan: begin
        sel_ctrl.vld = rd_vld_q;
        addr_d       = addr_q + IdxW'(1);
        if (addr_q == IdxW'(SLOTS - 1)) begin
          state_d = StLast;
        end
      end
      StLast: begin
        sel_ctrl.vld = rd_vld_q;
        state_d      = StCalc;
      end
      StCalc: begin
        state_d = StWrite;
      end
      StWrite: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          time_d      = time_q + 32'd1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      time_q      <= '0;
      used_q      <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      used_q      <= used_d;
      addr_q      <= addr_d;
      rd_vld_q    <= (state_q == StScan);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StScan) begin
      rd_idx_q <= addr_q;
    end
    if (state_q == StCalc) begin
      tat_q <= time_q + 32'd1 - {16'd0, best.arrival};
    end
    if (wb_go) begin
      out_q <= out_d;
    end
  end

  psched_mem #(
    .Slots (SLOTS),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (state_q == StScan),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  psched_sel #(
    .Slots (SLOTS),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sel_ctrl),
    .idx_i      (rd_idx_q),
    .rdata_i    (rdata),
    .used_i     (used_q[rd_idx_q]),
    .time_i     (time_q),
    .found_o    (found),
    .best_idx_o (best_idx),
    .best_o     (best),
    .active_o   (active)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/psched_chk.sv
// Port-level checker for the priority scheduler and its bind to the top level.
`timescale 1ns / 1ps

module psched_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input psched_pkg::in_t  in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input psched_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("Stalled result changed or dropped.");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.action == psched_pkg::ACT_TICK)) |=> in_stall_o)
    else $error("Input not stalled while a tick is in progress.");

  a_quick_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.action != psched_pkg::ACT_TICK)) |=> !in_stall_o)
    else $error("Load or clear stalled the input.");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.finished) |->
      (out_data_o.busy_res && (out_data_o.finish_time == out_data_o.tick_time + 32'd1)))
    else $error("Completed task reported with inconsistent times.");

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.busy_res) |->
      (!out_data_o.finished && (out_data_o.run_slot == 4'd0)))
    else $error("Idle tick reported a running task.");

endmodule

bind preemptive_priority_scheduler_top psched_chk u_psched_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
